### hw/rtl/priority_queue_extract_max_assert.svh
// Assertion helpers used by the sequencer, pqem_seq.
`ifndef PRIORITY_QUEUE_EXTRACT_MAX_ASSERT_SVH
`define PRIORITY_QUEUE_EXTRACT_MAX_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define PQEM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pqem check failed");

// Next-cycle implication, checked outside reset.
`define PQEM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pqem check failed");

`endif

### hw/rtl/pqem_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pqem_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int VAL_W     = 32;
  localparam int PRI_W     = 8;
  localparam int OP_W      = 2;

  typedef enum logic [OP_W-1:0] {
    OP_ADD     = 2'd0,
    OP_EXTRACT = 2'd1,
    OP_CLEAR   = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_REMOVE,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] val;
    logic [PRI_W-1:0]        pri;
  } entry_t;

  // load: write the slot at wr_idx; shift: move one place toward the head;
  // wrap: the tail slot takes the head entry instead of its right neighbor
  typedef struct packed {
    logic load;
    logic shift;
    logic wrap;
  } cell_ctrl_t;

endpackage

`default_nettype wire

### hw/rtl/priority_queue_extract_max.sv
`timescale 1ns / 1ps
`default_nettype none

// Bounded priority queue of (value, priority) pairs kept in arrival order in a
// row of DEPTH cells. op 0 adds a pair (ok=0 when full), op 1 removes the
// highest priority entry, the earliest one on a tie (ok=0 when empty), op 2
// clears; every request returns one result with the count and empty/full
// flags after the operation. A successful extract rotates the cell row once
// through all entries held to find the winner and once more to drop it and
// restore order. Requests are taken one at a time; a finished result waits in
// the output register while the next request is accepted, and the block
// stalls only if a second result is ready before the first has been taken.
module priority_queue_extract_max
  import pqem_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF,
  localparam int IDX_W = $clog2(DEPTH),
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic [OP_W-1:0]         in_op,
  input  wire logic signed [VAL_W-1:0] in_item_value,
  input  wire logic [PRI_W-1:0]        in_item_priority,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic                         out_ok,
  output logic signed [VAL_W-1:0]      out_value,
  output logic [PRI_W-1:0]             out_priority,
  output logic [CNT_W-1:0]             out_entry_count,
  output logic                         out_is_empty,
  output logic                         out_is_full
);

  cell_ctrl_t       ctrl;
  logic [IDX_W-1:0] wr_idx;
  logic [IDX_W-1:0] tail_idx;
  entry_t           wr_entry;
  entry_t           head_entry;
  entry_t           chain_q [DEPTH];

  assign head_entry = chain_q[0];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    entry_t right;
    if (i == DEPTH - 1) begin : g_last
      assign right = head_entry;
    end else begin : g_mid
      assign right = chain_q[i+1];
    end

    pqem_cell #(
      .DEPTH (DEPTH),
      .IDX   (i)
    ) u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .wr_idx      (wr_idx),
      .tail_idx    (tail_idx),
      .wr_entry    (wr_entry),
      .head_entry  (head_entry),
      .right_entry (right),
      .entry_q     (chain_q[i])
    );
  end

  pqem_seq #(
    .DEPTH (DEPTH)
  ) u_seq (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_op            (in_op),
    .in_item_value    (in_item_value),
    .in_item_priority (in_item_priority),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_ok           (out_ok),
    .out_value        (out_value),
    .out_priority     (out_priority),
    .out_entry_count  (out_entry_count),
    .out_is_empty     (out_is_empty),
    .out_is_full      (out_is_full),
    .head_entry       (head_entry),
    .ctrl             (ctrl),
    .wr_idx           (wr_idx),
    .tail_idx         (tail_idx),
    .wr_entry         (wr_entry)
  );

endmodule

`default_nettype wire

### hw/rtl/pqem_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module pqem_cell
  import pqem_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF,
  parameter int IDX   = 0,
  localparam int IDX_W = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire cell_ctrl_t       ctrl,
  input  wire logic [IDX_W-1:0] wr_idx,
  input  wire logic [IDX_W-1:0] tail_idx,
  input  wire entry_t           wr_entry,
  input  wire entry_t           head_entry,
  input  wire entry_t           right_entry,
  output entry_t                entry_q
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

  entry_t entry_r;
  entry_t entry_nxt;

  always_comb begin
    entry_nxt = entry_r;
    if (ctrl.load && (wr_idx == MY_IDX)) begin
      entry_nxt = wr_entry;
    end else if (ctrl.shift) begin
      entry_nxt = (ctrl.wrap && (tail_idx == MY_IDX)) ? head_entry : right_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry_q = entry_r;

endmodule

`default_nettype wire

### hw/rtl/pqem_seq.sv
`timescale 1ns / 1ps
`default_nettype none

`include "priority_queue_extract_max_assert.svh"

module pqem_seq
  import pqem_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF,
  localparam int IDX_W = $clog2(DEPTH),
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic [OP_W-1:0]         in_op,
  input  wire logic signed [VAL_W-1:0] in_item_value,
  input  wire logic [PRI_W-1:0]        in_item_priority,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic                         out_ok,
  output logic signed [VAL_W-1:0]      out_value,
  output logic [PRI_W-1:0]             out_priority,
  output logic [CNT_W-1:0]             out_entry_count,
  output logic                         out_is_empty,
  output logic                         out_is_full,
  input  wire entry_t                  head_entry,
  output cell_ctrl_t                   ctrl,
  output logic [IDX_W-1:0]             wr_idx,
  output logic [IDX_W-1:0]             tail_idx,
  output entry_t                       wr_entry
);

  state_t state_r, state_nxt;

  logic [CNT_W-1:0]        count_r, count_nxt;
  logic [CNT_W-1:0]        n_r, n_nxt;
  logic [IDX_W-1:0]        step_r, step_nxt;
  logic [IDX_W-1:0]        best_idx_r, best_idx_nxt;
  logic [PRI_W-1:0]        best_pri_r, best_pri_nxt;
  logic                    res_ok_r, res_ok_nxt;
  logic signed [VAL_W-1:0] res_val_r, res_val_nxt;
  logic [PRI_W-1:0]        res_pri_r, res_pri_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic                    out_ok_r, out_ok_nxt;
  logic signed [VAL_W-1:0] out_value_r, out_value_nxt;
  logic [PRI_W-1:0]        out_pri_r, out_pri_nxt;
  logic [CNT_W-1:0]        out_count_r, out_count_nxt;

  logic             accept;
  logic             last_step;
  logic [CNT_W-1:0] tail_full;

  assign in_ready  = (state_r == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign last_step = (CNT_W'(step_r) == (n_r - CNT_W'(1)));
  assign tail_full = count_r - CNT_W'(1);
  assign tail_idx  = tail_full[IDX_W-1:0];
  assign wr_idx    = count_r[IDX_W-1:0];
  assign wr_entry  = '{val: in_item_value, pri: in_item_priority};

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    n_nxt         = n_r;
    step_nxt      = step_r;
    best_idx_nxt  = best_idx_r;
    best_pri_nxt  = best_pri_r;
    res_ok_nxt    = res_ok_r;
    res_val_nxt   = res_val_r;
    res_pri_nxt   = res_pri_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_ok_nxt    = out_ok_r;
    out_value_nxt = out_value_r;
    out_pri_nxt   = out_pri_r;
    out_count_nxt = out_count_r;
    ctrl          = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          res_ok_nxt  = 1'b0;
          res_val_nxt = '0;
          res_pri_nxt = '0;
          state_nxt   = ST_DONE;
          unique case (op_t'(in_op))
            OP_ADD: begin
              if (count_r < CNT_W'(DEPTH)) begin
                ctrl.load  = 1'b1;
                count_nxt  = count_r + CNT_W'(1);
                res_ok_nxt = 1'b1;
              end
            end
            OP_EXTRACT: begin
              if (count_r != '0) begin
                n_nxt     = count_r;
                step_nxt  = '0;
                state_nxt = ST_SCAN;
              end
            end
            OP_CLEAR: begin
              count_nxt  = '0;
              res_ok_nxt = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end

      // rotate the whole queue once; strict compare keeps the earliest on a tie
      ST_SCAN: begin
        ctrl.shift = 1'b1;
        ctrl.wrap  = 1'b1;
        if ((step_r == '0) || (head_entry.pri > best_pri_r)) begin
          best_idx_nxt = step_r;
          best_pri_nxt = head_entry.pri;
        end
        if (last_step) begin
          step_nxt  = '0;
          state_nxt = ST_REMOVE;
        end else begin
          step_nxt = step_r + IDX_W'(1);
        end
      end

      // rotate again, dropping the winner when it reaches the head
      ST_REMOVE: begin
        ctrl.shift = 1'b1;
        if (step_r == best_idx_r) begin
          ctrl.wrap   = 1'b0;
          res_ok_nxt  = 1'b1;
          res_val_nxt = head_entry.val;
          res_pri_nxt = head_entry.pri;
          count_nxt   = count_r - CNT_W'(1);
        end else begin
          ctrl.wrap = 1'b1;
        end
        if (last_step) begin
          state_nxt = ST_DONE;
        end else begin
          step_nxt = step_r + IDX_W'(1);
        end
      end

      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_ok_nxt    = res_ok_r;
          out_value_nxt = res_val_r;
          out_pri_nxt   = res_pri_r;
          out_count_nxt = count_r;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    n_r         <= n_nxt;
    step_r      <= step_nxt;
    best_idx_r  <= best_idx_nxt;
    best_pri_r  <= best_pri_nxt;
    res_ok_r    <= res_ok_nxt;
    res_val_r   <= res_val_nxt;
    res_pri_r   <= res_pri_nxt;
    out_ok_r    <= out_ok_nxt;
    out_value_r <= out_value_nxt;
    out_pri_r   <= out_pri_nxt;
    out_count_r <= out_count_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_ok          = out_ok_r;
  assign out_value       = out_value_r;
  assign out_priority    = out_pri_r;
  assign out_entry_count = out_count_r;
  assign out_is_empty    = (out_count_r == '0);
  assign out_is_full     = (out_count_r == CNT_W'(DEPTH));

  `PQEM_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1, count_r <= CNT_W'(DEPTH))
  `PQEM_ASSERT_NOW(a_step_in_range, clk, rst_n,
    (state_r == ST_SCAN) || (state_r == ST_REMOVE), CNT_W'(step_r) < n_r)
  `PQEM_ASSERT_NOW(a_result_from_done, clk, rst_n, $rose(out_valid_r),
    $past(state_r) == ST_DONE)
  `PQEM_ASSERT_NEXT(a_extract_drops_one, clk, rst_n,
    (state_r == ST_REMOVE) && (state_nxt == ST_DONE), count_r == (n_r - CNT_W'(1)))

endmodule

`default_nettype wire

### tb/priority_queue_extract_max_test.sv
`timescale 1ns / 1ps

module priority_queue_extract_max_test;
  import pqem_pkg::*;

  localparam int DEPTH      = DEPTH_DEF;
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int QUIET_MAX  = 2000;
  localparam int PHASE_REQS = 325;

  typedef struct packed {
    logic                    ok;
    logic signed [VAL_W-1:0] value;
    logic [PRI_W-1:0]        pri;
    logic [CNT_W-1:0]        count;
    logic                    empty;
    logic                    full;
  } pq_status_t;

  // Tracks the queue contents and the status each request should return.
  class extract_max_scoreboard;
    logic signed [VAL_W-1:0] held_val [DEPTH];
    logic [PRI_W-1:0]        held_pri [DEPTH];
    int                      held_cnt;
    pq_status_t              pending_status [$];
    int                      mismatches;

    function new();
      held_cnt   = 0;
      mismatches = 0;
    endfunction

    function void note_request(op_t op, logic signed [VAL_W-1:0] val, logic [PRI_W-1:0] pri);
      pq_status_t st;
      int         best;
      st = '0;
      case (op)
        OP_ADD: begin
          if (held_cnt < DEPTH) begin
            held_val[held_cnt] = val;
            held_pri[held_cnt] = pri;
            held_cnt++;
            st.ok = 1'b1;
          end
        end
        OP_EXTRACT: begin
          if (held_cnt > 0) begin
            // strict compare keeps the earliest entry on a tie
            best = 0;
            for (int i = 1; i < held_cnt; i++)
              if (held_pri[i] > held_pri[best]) best = i;
            st.value = held_val[best];
            st.pri   = held_pri[best];
            for (int i = best; i + 1 < held_cnt; i++) begin
              held_val[i] = held_val[i + 1];
              held_pri[i] = held_pri[i + 1];
            end
            held_cnt--;
            st.ok = 1'b1;
          end
        end
        OP_CLEAR: begin
          held_cnt = 0;
          st.ok    = 1'b1;
        end
        default: ;
      endcase
      st.count = CNT_W'(held_cnt);
      st.empty = (held_cnt == 0);
      st.full  = (held_cnt == DEPTH);
      pending_status.push_back(st);
    endfunction

    function void report(string what, pq_status_t want, pq_status_t got);
      mismatches++;
      if (mismatches <= 10) begin
        $write("%0t %s: expected ok=%0b value=%0d pri=%0d count=%0d empty=%0b full=%0b",
               $time, what, want.ok, want.value, want.pri, want.count, want.empty,
               want.full);
        $display(", got ok=%0b value=%0d pri=%0d count=%0d empty=%0b full=%0b",
                 got.ok, got.value, got.pri, got.count, got.empty, got.full);
      end
    endfunction

    function void check_result(pq_status_t got);
      pq_status_t want;
      if (pending_status.size() == 0) begin
        report("result with no request pending", '0, got);
        return;
      end
      want = pending_status.pop_front();
      if (got.ok !== want.ok || got.value !== want.value || got.pri !== want.pri ||
          got.count !== want.count || got.empty !== want.empty || got.full !== want.full)
        report("status mismatch", want, got);
    endfunction
  endclass

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic [OP_W-1:0]         in_op = OP_ADD;
  logic signed [VAL_W-1:0] in_item_value = '0;
  logic [PRI_W-1:0]        in_item_priority = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic                    out_ok;
  logic signed [VAL_W-1:0] out_value;
  logic [PRI_W-1:0]        out_priority;
  logic [CNT_W-1:0]        out_entry_count;
  logic                    out_is_empty;
  logic                    out_is_full;

  extract_max_scoreboard sb;
  int requests_taken = 0;
  int gap_pct = 0;
  int stall_pct = 0;

  priority_queue_extract_max dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_op            (in_op),
    .in_item_value    (in_item_value),
    .in_item_priority (in_item_priority),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_ok           (out_ok),
    .out_value        (out_value),
    .out_priority     (out_priority),
    .out_entry_count  (out_entry_count),
    .out_is_empty     (out_is_empty),
    .out_is_full      (out_is_full)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      sb.note_request(op_t'(in_op), in_item_value, in_item_priority);
      requests_taken++;
    end
    if (rst_n && out_valid && out_ready)
      sb.check_result('{out_ok, out_value, out_priority, out_entry_count, out_is_empty,
                        out_is_full});
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_MAX) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("Regression FAIL");
    $finish;
  end

  // Called at a falling edge; returns at the falling edge after the request is taken.
  task automatic send_request(op_t op, logic signed [VAL_W-1:0] val, logic [PRI_W-1:0] pri);
    int seen;
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid         <= 1'b1;
    in_op            <= op;
    in_item_value    <= val;
    in_item_priority <= pri;
    seen = requests_taken;
    do @(negedge clk); while (requests_taken == seen);
  endtask

  task automatic hold_until_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (sb.pending_status.size() != 0);
  endtask

  task automatic directed_requests();
    logic [PRI_W-1:0]        pri_list [16] = '{8'd0, 8'd255, 8'd17, 8'd255, 8'd128, 8'd17,
                                               8'd0, 8'd255, 8'd1, 8'd254, 8'd17, 8'd128,
                                               8'd0, 8'd64, 8'd255, 8'd2};
    logic signed [VAL_W-1:0] val;
    send_request(OP_EXTRACT, 32'sd99, 8'd255);
    send_request(OP_CLEAR, 32'sd0, 8'd0);
    for (int i = 0; i < 16; i++) begin
      case (i)
        0:       val = 32'sh7FFFFFFF;
        1:       val = 32'sh80000000;
        2:       val = 32'sh0;
        3:       val = -32'sd1;
        4:       val = 32'sh55555555;
        5:       val = 32'shAAAAAAAA;
        default: val = $urandom;
      endcase
      send_request(OP_ADD, val, pri_list[i]);
    end
    // queue is full: this add must be dropped
    send_request(OP_ADD, 32'sd123, 8'd255);
    repeat (3) send_request(OP_EXTRACT, 32'sd0, 8'd0);
    send_request(OP_CLEAR, 32'sd0, 8'd0);
    send_request(OP_EXTRACT, 32'sd0, 8'd0);
  endtask

  task automatic random_request(int add_pct, int pri_mode);
    int                      r;
    op_t                     op;
    logic signed [VAL_W-1:0] val;
    logic [PRI_W-1:0]        pri;
    r = $urandom_range(99);
    if (r < 2) op = OP_CLEAR;
    else if (r < 2 + add_pct) op = OP_ADD;
    else op = OP_EXTRACT;
    case ($urandom_range(9))
      0:       val = ($urandom_range(1) == 0) ? 32'sh7FFFFFFF : 32'sh80000000;
      1:       val = ($urandom_range(1) == 0) ? 32'sh0 : -32'sd1;
      default: val = $urandom;
    endcase
    case (pri_mode)
      0:       pri = PRI_W'($urandom_range(3));          // dense ties
      1:       pri = PRI_W'($urandom_range(255));
      default: begin
        case ($urandom_range(3))
          0:       pri = 8'd0;
          1:       pri = 8'd1;
          2:       pri = 8'd254;
          default: pri = 8'd255;
        endcase
      end
    endcase
    send_request(op, val, pri);
  endtask

  initial begin
    int add_pct;
    int pri_mode;
    sb = new();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    directed_requests();
    add_pct  = 50;
    pri_mode = 1;
    for (int phase = 0; phase < 4; phase++) begin
      hold_until_drained();
      case (phase)
        0:       begin gap_pct = 0;  stall_pct = 0;  end
        1:       begin gap_pct = 50; stall_pct = 0;  end
        2:       begin gap_pct = 0;  stall_pct = 50; end
        default: begin gap_pct = 30; stall_pct = 30; end
      endcase
      for (int n = 0; n < PHASE_REQS; n++) begin
        if (n % 40 == 0) begin
          // swing the fill level: mostly adds fills to full, mostly extracts drains
          case ($urandom_range(2))
            0:       add_pct = 85;
            1:       add_pct = 50;
            default: add_pct = 18;
          endcase
          pri_mode = $urandom_range(2);
        end
        if ($urandom_range(149) == 0) hold_until_drained();
        random_request(add_pct, pri_mode);
      end
    end
    in_valid <= 1'b0;
    while (sb.pending_status.size() != 0) @(posedge clk);
    repeat (64) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending_status.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+hw/rtl
hw/rtl/pqem_pkg.sv
hw/rtl/pqem_cell.sv
hw/rtl/pqem_seq.sv
hw/rtl/priority_queue_extract_max.sv
tb/priority_queue_extract_max_test.sv
